FILE: src/base64_stream_decoder_unit_defines.svh
// assertion macros for the base64 stream decoder checker
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define B64SD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define B64SD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/b64sd_pkg.sv
// types, constants and character classing for the base64 stream decoder
`default_nettype none

package b64sd_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       last;
    logic [1:0] error_code;
  } out_beat_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BAD_CHR = 2'd1;
  localparam logic [1:0] ERR_BAD_PAD = 2'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int MAX_RES = 3;
  localparam int RES_N_W = $clog2(MAX_RES + 1);
  localparam int RES_I_W = $clog2(MAX_RES);

  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SLASH   = 8'h2F;
  localparam logic [7:0] CHR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_SPACE   = 8'h20;

  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] VAL_PLUS   = 6'd62;
  localparam logic [5:0] VAL_SLASH  = 6'd63;

  typedef enum logic [1:0] {
    SYM_DATA  = 2'd0,
    SYM_PAD   = 2'd1,
    SYM_SKIP  = 2'd2,
    SYM_BAD   = 2'd3
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] value;
  } sym_t;

  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s.kind  = SYM_BAD;
    s.value = '0;
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
      s.kind  = SYM_DATA;
      s.value = 6'(c - CHR_UPPER_A);
    end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
      s.kind  = SYM_DATA;
      s.value = 6'(c - CHR_LOWER_A + LOWER_BASE);
    end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
      s.kind  = SYM_DATA;
      s.value = 6'(c - CHR_ZERO + DIGIT_BASE);
    end else if (c == CHR_PLUS) begin
      s.kind  = SYM_DATA;
      s.value = VAL_PLUS;
    end else if (c == CHR_SLASH) begin
      s.kind  = SYM_DATA;
      s.value = VAL_SLASH;
    end else if (c == CHR_EQUALS) begin
      s.kind  = SYM_PAD;
    end else if (c == CHR_LF || c == CHR_CR || c == CHR_TAB || c == CHR_SPACE) begin
      s.kind  = SYM_SKIP;
    end
    return s;
  endfunction

  function automatic out_beat_t mk_beat(input logic [7:0] val, input logic valid,
                                        input logic last, input logic [1:0] err);
    out_beat_t b;
    b.byte_value = val;
    b.byte_valid = valid;
    b.last       = last;
    b.error_code = err;
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: src/base64_stream_decoder_unit.sv
// base64 stream decoder: one character per beat in, decoded bytes out
//
// in_data carries one character and an end-of-message flag per beat; a beat
// is taken when in_valid is high and in_stall is low. out_data carries one
// decoded byte, an empty last marker or an error report per beat, taken when
// out_valid is high and out_stall is low. out_data.last closes every message.
// Results are registered in a four-entry result queue and show on out_data
// from its head. Decoding state is updated in the same cycle the character
// is taken. One character is taken per cycle while in_stall is low;
// in_stall is high while more than one result waits in the queue, so an
// end-of-message character that releases three results holds off further
// characters until the queue is down to one result.
// Held bytes lag the decode by two bytes, as padding at the end of a message
// can only be resolved then.
// While out_stall is high the queue holds and in_stall rises once it holds
// two results. Reset empties the queue and clears all decoding state.
`default_nettype none

module base64_stream_decoder_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  b64sd_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output b64sd_pkg::out_beat_t out_data
);

  logic [5:0] lo_bits_r, lo_bits_nxt;
  logic [2:0] lo_cnt_r, lo_cnt_nxt;
  logic [1:0] pad_cnt_r, pad_cnt_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic       discard_r, discard_nxt;

  b64sd_pkg::out_beat_t q_r [b64sd_pkg::Q_DEPTH];
  b64sd_pkg::out_beat_t q_nxt [b64sd_pkg::Q_DEPTH];
  logic [b64sd_pkg::Q_CNT_W-1:0] q_cnt_r, q_cnt_nxt;

  b64sd_pkg::out_beat_t res [b64sd_pkg::MAX_RES];
  logic [b64sd_pkg::RES_N_W-1:0] res_n;

  logic in_acc, out_pop;

  assign in_stall  = (q_cnt_r > b64sd_pkg::Q_CNT_W'(1));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_data  = q_r[0];

  // character decode and hold-back
  always_comb begin
    b64sd_pkg::sym_t s;
    logic [5:0]  v;
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [7:0]  byte_new;
    logic [1:0]  keep;
    logic        eom;
    s            = b64sd_pkg::sym_decode(in_data.char_code);
    eom          = in_data.end_of_message;
    v            = '0;
    acc          = '0;
    cnt          = '0;
    byte_new     = '0;
    keep         = '0;
    lo_bits_nxt  = lo_bits_r;
    lo_cnt_nxt   = lo_cnt_r;
    pad_cnt_nxt  = pad_cnt_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    discard_nxt  = discard_r;
    res_n        = '0;
    for (int i = 0; i < b64sd_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end
    if (in_acc) begin
      if (discard_r) begin
        if (eom) begin
          discard_nxt  = 1'b0;
          lo_bits_nxt  = '0;
          lo_cnt_nxt   = '0;
          pad_cnt_nxt  = '0;
          held_cnt_nxt = '0;
        end
      end else if (s.kind == b64sd_pkg::SYM_BAD ||
                   (s.kind == b64sd_pkg::SYM_PAD && pad_cnt_r >= 2'd2)) begin
        res[0] = b64sd_pkg::mk_beat(8'd0, 1'b0, 1'b1,
                   (s.kind == b64sd_pkg::SYM_BAD) ? b64sd_pkg::ERR_BAD_CHR
                                                  : b64sd_pkg::ERR_BAD_PAD);
        res_n        = b64sd_pkg::RES_N_W'(1);
        lo_bits_nxt  = '0;
        lo_cnt_nxt   = '0;
        pad_cnt_nxt  = '0;
        held_cnt_nxt = '0;
        discard_nxt  = !eom;
      end else begin
        if (s.kind != b64sd_pkg::SYM_SKIP) begin
          if (s.kind == b64sd_pkg::SYM_PAD) begin
            pad_cnt_nxt = pad_cnt_r + 2'd1;
          end else begin
            v = s.value;
          end
          acc = {lo_bits_r, v};
          cnt = {1'b0, lo_cnt_r} + 4'd6;
          if (cnt >= 4'd8) begin
            cnt      = cnt - 4'd8;
            byte_new = 8'(acc >> cnt);
            acc      = acc & ((12'd1 << cnt) - 12'd1);
            if (held_cnt_r >= 2'd2) begin
              res[0]    = b64sd_pkg::mk_beat(held0_r, 1'b1, 1'b0, b64sd_pkg::ERR_NONE);
              res_n     = b64sd_pkg::RES_N_W'(1);
              held0_nxt = held1_r;
              held1_nxt = byte_new;
            end else begin
              if (held_cnt_r[0]) begin
                held1_nxt = byte_new;
              end else begin
                held0_nxt = byte_new;
              end
              held_cnt_nxt = held_cnt_r + 2'd1;
            end
          end
          lo_bits_nxt = acc[5:0];
          lo_cnt_nxt  = cnt[2:0];
        end
        if (eom) begin
          if (pad_cnt_nxt > held_cnt_nxt) begin
            res[res_n[b64sd_pkg::RES_I_W-1:0]] =
              b64sd_pkg::mk_beat(8'd0, 1'b0, 1'b1, b64sd_pkg::ERR_BAD_PAD);
            res_n = res_n + b64sd_pkg::RES_N_W'(1);
          end else begin
            keep = held_cnt_nxt - pad_cnt_nxt;
            if (keep == 2'd0) begin
              res[res_n[b64sd_pkg::RES_I_W-1:0]] =
                b64sd_pkg::mk_beat(8'd0, 1'b0, 1'b1, b64sd_pkg::ERR_NONE);
              res_n = res_n + b64sd_pkg::RES_N_W'(1);
            end else begin
              res[res_n[b64sd_pkg::RES_I_W-1:0]] =
                b64sd_pkg::mk_beat(held0_nxt, 1'b1, keep == 2'd1, b64sd_pkg::ERR_NONE);
              res_n = res_n + b64sd_pkg::RES_N_W'(1);
              if (keep == 2'd2) begin
                res[res_n[b64sd_pkg::RES_I_W-1:0]] =
                  b64sd_pkg::mk_beat(held1_nxt, 1'b1, 1'b1, b64sd_pkg::ERR_NONE);
                res_n = res_n + b64sd_pkg::RES_N_W'(1);
              end
            end
          end
          lo_bits_nxt  = '0;
          lo_cnt_nxt   = '0;
          pad_cnt_nxt  = '0;
          held_cnt_nxt = '0;
        end
      end
    end
  end

  // result queue: pop from the head, append new results behind what is left
  always_comb begin
    logic [b64sd_pkg::Q_CNT_W-1:0] base;
    logic [b64sd_pkg::Q_CNT_W-1:0] rel;
    base = q_cnt_r - b64sd_pkg::Q_CNT_W'(out_pop);
    rel  = '0;
    for (int i = 0; i < b64sd_pkg::Q_DEPTH; i++) begin
      if (out_pop && i < b64sd_pkg::Q_DEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      rel = b64sd_pkg::Q_CNT_W'(i) - base;
      if (b64sd_pkg::Q_CNT_W'(i) >= base &&
          rel < b64sd_pkg::Q_CNT_W'(res_n)) begin
        q_nxt[i] = res[rel[b64sd_pkg::RES_I_W-1:0]];
      end
    end
    q_cnt_nxt = base + b64sd_pkg::Q_CNT_W'(res_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_bits_r  <= '0;
      lo_cnt_r   <= '0;
      pad_cnt_r  <= '0;
      held_cnt_r <= '0;
      discard_r  <= 1'b0;
      q_cnt_r    <= '0;
    end else begin
      lo_bits_r  <= lo_bits_nxt;
      lo_cnt_r   <= lo_cnt_nxt;
      pad_cnt_r  <= pad_cnt_nxt;
      held_cnt_r <= held_cnt_nxt;
      discard_r  <= discard_nxt;
      q_cnt_r    <= q_cnt_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    for (int i = 0; i < b64sd_pkg::Q_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

`default_nettype wire

FILE: src/b64sd_checker.sv
// port-level checks for the base64 stream decoder, bound to the top level
`default_nettype none
`include "base64_stream_decoder_unit_defines.svh"

module b64sd_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_stall,
  input b64sd_pkg::out_beat_t out_data
);

  `B64SD_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "result beat right after reset")
  `B64SD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `B64SD_ASSERT_NOW(a_err_last, out_valid && out_data.error_code != b64sd_pkg::ERR_NONE, out_data.last && !out_data.byte_valid, "error beat not a last-only beat")
  `B64SD_ASSERT_NOW(a_empty_zero, out_valid && !out_data.byte_valid, out_data.last && out_data.byte_value == 8'd0, "empty beat not last or not zero")
  `B64SD_ASSERT_NOW(a_err_code, out_valid, out_data.error_code == b64sd_pkg::ERR_NONE || out_data.error_code == b64sd_pkg::ERR_BAD_CHR || out_data.error_code == b64sd_pkg::ERR_BAD_PAD, "unknown error code")

endmodule

bind base64_stream_decoder_unit b64sd_checker u_b64sd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/tb_base64_stream_decoder_unit.sv
// self-checking testbench for base64_stream_decoder_unit with a decoded-byte scoreboard
`default_nettype none

module tb_base64_stream_decoder_unit;

  localparam int ITEM_TARGET = 480;
  localparam int QUIET_FROM  = 420;
  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 12;

  class decoded_byte_board;
    b64sd_pkg::out_beat_t pending_beats[$];
    int         mismatches = 0;
    logic [5:0] spare_bits = '0;
    int         spare_count = 0;
    int         pads_seen = 0;
    logic [7:0] held[2];
    int         held_n = 0;
    bit         skipping_msg = 1'b0;

    function void clear_msg();
      spare_bits  = '0;
      spare_count = 0;
      pads_seen   = 0;
      held_n      = 0;
    endfunction

    function void note_beat(logic [7:0] val, logic valid, logic last, logic [1:0] err);
      b64sd_pkg::out_beat_t b;
      b.byte_value = val;
      b.byte_valid = valid;
      b.last       = last;
      b.error_code = err;
      pending_beats.insert(pending_beats.size(), b);
    endfunction

    function b64sd_pkg::sym_kind_t classify(input logic [7:0] c, output logic [5:0] v);
      v = '0;
      if (c >= b64sd_pkg::CHR_UPPER_A && c <= b64sd_pkg::CHR_UPPER_Z) begin
        v = 6'(c - b64sd_pkg::CHR_UPPER_A);
        return b64sd_pkg::SYM_DATA;
      end
      if (c >= b64sd_pkg::CHR_LOWER_A && c <= b64sd_pkg::CHR_LOWER_Z) begin
        v = 6'(c - b64sd_pkg::CHR_LOWER_A + b64sd_pkg::LOWER_BASE);
        return b64sd_pkg::SYM_DATA;
      end
      if (c >= b64sd_pkg::CHR_ZERO && c <= b64sd_pkg::CHR_NINE) begin
        v = 6'(c - b64sd_pkg::CHR_ZERO + b64sd_pkg::DIGIT_BASE);
        return b64sd_pkg::SYM_DATA;
      end
      case (c)
        b64sd_pkg::CHR_PLUS: begin
          v = b64sd_pkg::VAL_PLUS;
          return b64sd_pkg::SYM_DATA;
        end
        b64sd_pkg::CHR_SLASH: begin
          v = b64sd_pkg::VAL_SLASH;
          return b64sd_pkg::SYM_DATA;
        end
        b64sd_pkg::CHR_EQUALS: return b64sd_pkg::SYM_PAD;
        b64sd_pkg::CHR_LF, b64sd_pkg::CHR_CR, b64sd_pkg::CHR_TAB,
        b64sd_pkg::CHR_SPACE: return b64sd_pkg::SYM_SKIP;
        default: return b64sd_pkg::SYM_BAD;
      endcase
    endfunction

    function void take_char(b64sd_pkg::in_beat_t b);
      b64sd_pkg::sym_kind_t kind;
      logic [5:0] v;
      int         acc;
      int         cnt;
      int         keep;
      logic [7:0] new_byte;
      if (skipping_msg) begin
        if (b.end_of_message) begin
          skipping_msg = 1'b0;
          clear_msg();
        end
        return;
      end
      kind = classify(b.char_code, v);
      if (kind == b64sd_pkg::SYM_BAD || (kind == b64sd_pkg::SYM_PAD && pads_seen >= 2)) begin
        note_beat(8'h00, 1'b0, 1'b1, (kind == b64sd_pkg::SYM_BAD) ? b64sd_pkg::ERR_BAD_CHR
                                                                   : b64sd_pkg::ERR_BAD_PAD);
        clear_msg();
        skipping_msg = !b.end_of_message;
        return;
      end
      if (kind != b64sd_pkg::SYM_SKIP) begin
        if (kind == b64sd_pkg::SYM_PAD) begin
          pads_seen++;
          v = '0;
        end
        acc = (int'(spare_bits) << 6) | int'(v);
        cnt = spare_count + 6;
        if (cnt >= 8) begin
          cnt -= 8;
          new_byte = 8'((acc >> cnt) & 'hFF);
          acc &= (1 << cnt) - 1;
          if (held_n == 2) begin
            note_beat(held[0], 1'b1, 1'b0, b64sd_pkg::ERR_NONE);
            held[0] = held[1];
            held[1] = new_byte;
          end else begin
            held[held_n] = new_byte;
            held_n++;
          end
        end
        spare_bits  = 6'(acc);
        spare_count = cnt;
      end
      if (b.end_of_message) begin
        if (pads_seen > held_n) begin
          note_beat(8'h00, 1'b0, 1'b1, b64sd_pkg::ERR_BAD_PAD);
        end else begin
          keep = held_n - pads_seen;
          if (keep == 0) begin
            note_beat(8'h00, 1'b0, 1'b1, b64sd_pkg::ERR_NONE);
          end else begin
            for (int i = 0; i < keep; i++)
              note_beat(held[i], 1'b1, i + 1 == keep, b64sd_pkg::ERR_NONE);
          end
        end
        clear_msg();
      end
    endfunction

    function void check_beat(b64sd_pkg::out_beat_t got);
      b64sd_pkg::out_beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got value %02h valid %b last %b err %0d",
                 $time, got.byte_value, got.byte_valid, got.last, got.error_code);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.byte_value !== want.byte_value || got.byte_valid !== want.byte_valid ||
          got.last !== want.last || got.error_code !== want.error_code) begin
        $display("%0t: expected value %02h valid %b last %b err %0d, got value %02h valid %b last %b err %0d",
                 $time, want.byte_value, want.byte_valid, want.last, want.error_code,
                 got.byte_value, got.byte_valid, got.last, got.error_code);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  b64sd_pkg::in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  b64sd_pkg::out_beat_t out_data;

  decoded_byte_board sb;
  logic [7:0]        msg_chars[$];
  int                data_items = 0;
  int                idle_pct = 20;
  bit                quiet_tail = 1'b0;
  int                cycles = 0;

  base64_stream_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_char(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
  end

  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        burst = $urandom_range(1, 3);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [7:0] alpha_char(int v);
    if (v < 26) return b64sd_pkg::CHR_UPPER_A + 8'(v);
    if (v < 52) return b64sd_pkg::CHR_LOWER_A + 8'(v - 26);
    if (v < 62) return b64sd_pkg::CHR_ZERO + 8'(v - 52);
    return (v == 62) ? b64sd_pkg::CHR_PLUS : b64sd_pkg::CHR_SLASH;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 3))
      0: return b64sd_pkg::CHR_LF;
      1: return b64sd_pkg::CHR_CR;
      2: return b64sd_pkg::CHR_TAB;
      default: return b64sd_pkg::CHR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return alpha_char($urandom_range(0, 63));
    if (pick < 65) return b64sd_pkg::CHR_EQUALS;
    if (pick < 75) return space_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void load_text(string s);
    msg_chars.delete();
    for (int i = 0; i < s.len(); i++) msg_chars.insert(msg_chars.size(), s[i]);
  endfunction

  function automatic void build_encoded(int n_bytes);
    int acc;
    int nbits;
    msg_chars.delete();
    acc = 0;
    nbits = 0;
    for (int i = 0; i < n_bytes; i++) begin
      acc = (acc << 8) | $urandom_range(0, 255);
      nbits += 8;
      while (nbits >= 6) begin
        nbits -= 6;
        msg_chars.insert(msg_chars.size(), alpha_char((acc >> nbits) & 63));
      end
      acc &= (1 << nbits) - 1;
    end
    if (nbits > 0) msg_chars.insert(msg_chars.size(), alpha_char((acc << (6 - nbits)) & 63));
    while (msg_chars.size() % 4 != 0) msg_chars.insert(msg_chars.size(), b64sd_pkg::CHR_EQUALS);
  endfunction

  function automatic void sprinkle_spaces();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    for (int k = 0; k < n; k++) msg_chars.insert($urandom_range(0, msg_chars.size()), space_char());
    if (msg_chars.size() == 0) msg_chars.insert(0, space_char());
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eom);
    int gap;
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.char_code = c;
    in_data.end_of_message = eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(c == b64sd_pkg::CHR_LF || c == b64sd_pkg::CHR_CR || c == b64sd_pkg::CHR_TAB ||
          c == b64sd_pkg::CHR_SPACE)) data_items++;
    if (data_items >= QUIET_FROM) quiet_tail = 1'b1;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_chars.size(); i++) send_char(msg_chars[i], i == msg_chars.size() - 1);
  endtask

  task automatic send_text(string s);
    load_text(s);
    send_message();
  endtask

  initial begin
    int mode;
    sb = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // padding, full alphabet extremes, skipped whitespace, bad padding, bad characters
    send_text("TQ==");
    send_text("+/ 9z");
    send_text("\t");
    send_text("=\n");
    send_text("QQ===");
    send_text("A=AA");
    msg_chars.delete();
    msg_chars.insert(msg_chars.size(), 8'h00);
    msg_chars.insert(msg_chars.size(), 8'hFF);
    send_message();
    msg_chars.delete();
    msg_chars.insert(msg_chars.size(), 8'hFF);
    send_message();

    while (data_items < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      mode = $urandom_range(0, 99);
      if (mode < 72) begin
        build_encoded($urandom_range(0, 7));
        sprinkle_spaces();
      end else if (mode < 88) begin
        build_encoded($urandom_range(1, 7));
        msg_chars[$urandom_range(0, msg_chars.size() - 1)] = noise_char();
        sprinkle_spaces();
      end else begin
        msg_chars.delete();
        repeat ($urandom_range(1, 8)) msg_chars.insert(msg_chars.size(), noise_char());
      end
      send_message();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
